>>> rtl/lst_pkg.sv
// Shared types and constants of the LCD scanline and status-mode timer.
`timescale 1ns / 1ps
`default_nettype none

package lst_pkg;

    localparam int LINE_W = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_DISPLAY_ENABLE     = 2'd0;
    localparam logic [1:0] REG_LINE_COMPARE       = 2'd1;
    localparam logic [1:0] REG_STATUS_IRQ_ENABLES = 2'd2;

    // Status mode codes
    localparam logic [1:0] MODE_HBLANK  = 2'd0;
    localparam logic [1:0] MODE_VBLANK  = 2'd1;
    localparam logic [1:0] MODE_OAMSCAN = 2'd2;
    localparam logic [1:0] MODE_DRAW    = 2'd3;

    // Bit positions in the status interrupt enables
    localparam int IRQ_HBLANK_BIT  = 0;
    localparam int IRQ_VBLANK_BIT  = 1;
    localparam int IRQ_OAMSCAN_BIT = 2;
    localparam int IRQ_COMPARE_BIT = 3;

    // Dot positions where the mode changes within a line
    localparam logic [7:0] OAM_SCAN_END = 8'd80;
    localparam logic [7:0] DRAW_END     = 8'd252;

    typedef struct packed {
        logic [LINE_W-1:0] line_count;
        logic [1:0]        last_mode;
        logic [1:0]        status_mode;
        logic              coincidence;
    } line_state_t;

    typedef struct packed {
        logic [LINE_W-1:0] line_number;
        logic [1:0]        display_mode;
        logic              compare_match;
        logic              vblank_request;
        logic              status_request;
        logic              line_done;
        logic [LINE_W-1:0] done_line_number;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/lcd_scanline_mode_timer.sv
// Top level of the LCD scanline and status-mode timer.
// Usage:
// - Input channel (in_valid/in_ready, dot_count): each request is one tick
//   of dot_count dot clocks. The timer advances its dot and line counters,
//   derives the status mode and raises vblank/status requests when enabled.
// - Output channel (out_valid/out_ready): exactly one result per request,
//   in order: line number, mode bits, coincidence bit, vblank and status
//   requests and a line-done strobe with the finished visible line.
// - Timing: the result is registered, valid in the cycle after acceptance.
// - Throughput: one request per cycle unless the output stalls. The timer
//   state updates in the same cycle the request is accepted; one result
//   register parts the channels, so a new request is taken whenever that
//   register is empty or drains in the same cycle.
// - Stall: while out_ready is low and a result waits, in_ready drops and
//   the timer state holds.
// - Configuration: cfg_write_en writes cfg_data into register cfg_index
//   (0 display enable, 1 line compare, 2 status interrupt enables) at once.
//   Writes to other indexes are dropped. Write only while idle.
// - Reset: counters, mode bits, coincidence and registers clear, the last
//   mode starts as OAM scan, and the result register empties.
`timescale 1ns / 1ps
`default_nettype none

module lcd_scanline_mode_timer #(
    parameter int DOTS_PER_LINE = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // configuration write port
    input  wire logic       cfg_write_en,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    // tick requests
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] dot_count,
    // results
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      line_number,
    output logic [1:0]      display_mode,
    output logic            compare_match,
    output logic            vblank_request,
    output logic            status_request,
    output logic            line_done,
    output logic [7:0]      done_line_number
);

    localparam int DOT_W = $clog2(DOTS_PER_LINE);
    localparam logic [DOT_W-1:0]           DOTS_D = DOT_W'(DOTS_PER_LINE);
    localparam logic [lst_pkg::LINE_W-1:0] VIS_L  = lst_pkg::LINE_W'(VISIBLE_LINES);
    localparam logic [lst_pkg::LINE_W-1:0] TOT_L  = lst_pkg::LINE_W'(TOTAL_LINES);

    // configuration registers
    logic                  display_enable_reg;
    logic [7:0]            line_compare_reg;
    logic [3:0]            status_irq_enables_reg;

    // timer state
    logic [DOT_W-1:0]      dot_position_reg;
    logic [DOT_W-1:0]      dot_position_next;
    lst_pkg::line_state_t  state_reg;
    lst_pkg::line_state_t  state_next;

    // result register
    logic                  out_valid_reg;
    lst_pkg::result_t      result_reg;
    lst_pkg::result_t      result_next;

    logic                  in_accept;

    // Take a request when the result register is empty or drains now.
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg     <= 1'b0;
            line_compare_reg       <= '0;
            status_irq_enables_reg <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                lst_pkg::REG_DISPLAY_ENABLE:     display_enable_reg     <= cfg_data[0];
                lst_pkg::REG_LINE_COMPARE:       line_compare_reg       <= cfg_data;
                lst_pkg::REG_STATUS_IRQ_ENABLES: status_irq_enables_reg <= cfg_data[3:0];
                default:                         ;  // drop writes beyond the map
            endcase
        end
    end

    lst_next #(
        .DOTS_PER_LINE (DOTS_PER_LINE),
        .VISIBLE_LINES (VISIBLE_LINES),
        .TOTAL_LINES   (TOTAL_LINES),
        .DOT_W         (DOT_W)
    ) u_next (
        .display_enable     (display_enable_reg),
        .line_compare       (line_compare_reg),
        .status_irq_enables (status_irq_enables_reg),
        .dot_count          (dot_count),
        .dot_position       (dot_position_reg),
        .state              (state_reg),
        .dot_position_next  (dot_position_next),
        .state_next         (state_next),
        .result             (result_next)
    );

    // Advance the timer state only on an accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_position_reg      <= '0;
            state_reg.line_count  <= '0;
            state_reg.last_mode   <= lst_pkg::MODE_OAMSCAN;
            state_reg.status_mode <= lst_pkg::MODE_HBLANK;
            state_reg.coincidence <= 1'b0;
        end
        else if (in_accept)
        begin
            dot_position_reg <= dot_position_next;
            state_reg        <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    // Payload holds while the receiver stalls.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid        = out_valid_reg;
    assign line_number      = result_reg.line_number;
    assign display_mode     = result_reg.display_mode;
    assign compare_match    = result_reg.compare_match;
    assign vblank_request   = result_reg.vblank_request;
    assign status_request   = result_reg.status_request;
    assign line_done        = result_reg.line_done;
    assign done_line_number = result_reg.done_line_number;

    // The dot counter always stays inside one line.
    a_dot_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        dot_position_reg < DOTS_D)
        else $error("dot position beyond end of line");

    // The line counter wraps at the total line count.
    a_line_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (TOT_L == VIS_L) || (state_reg.line_count < TOT_L))
        else $error("line counter past total lines");

    // A vblank request comes only with the first blank line.
    a_vblank_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && vblank_request |-> line_number == VIS_L)
        else $error("vblank request on wrong line");

    // A finished line reported for rendering is always visible.
    a_done_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && line_done |-> done_line_number < VIS_L)
        else $error("line done on a blank line");

    // A waiting result blocks new requests, so state cannot run ahead.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(state_reg) && $stable(dot_position_reg))
        else $error("timer state moved during output stall");

endmodule

`default_nettype wire

>>> rtl/lst_next.sv
// Next-state and result logic for one dot tick of the scanline timer.
`timescale 1ns / 1ps
`default_nettype none

module lst_next #(
    parameter int DOTS_PER_LINE = 456,
    parameter int VISIBLE_LINES = 144,
    parameter int TOTAL_LINES   = 154,
    parameter int DOT_W         = 9
) (
    input  wire logic                  display_enable,
    input  wire logic [7:0]            line_compare,
    input  wire logic [3:0]            status_irq_enables,
    input  wire logic [7:0]            dot_count,
    input  wire logic [DOT_W-1:0]      dot_position,
    input  wire lst_pkg::line_state_t  state,
    output logic      [DOT_W-1:0]      dot_position_next,
    output lst_pkg::line_state_t       state_next,
    output lst_pkg::result_t           result
);

    localparam logic [DOT_W:0]            DOTS_L   = (DOT_W+1)'(DOTS_PER_LINE);
    localparam logic [DOT_W-1:0]          OAM_END  = DOT_W'(lst_pkg::OAM_SCAN_END);
    localparam logic [DOT_W-1:0]          DRAW_END = DOT_W'(lst_pkg::DRAW_END);
    localparam logic [lst_pkg::LINE_W-1:0] VIS_L   = lst_pkg::LINE_W'(VISIBLE_LINES);
    localparam logic [lst_pkg::LINE_W-1:0] TOT_L   = lst_pkg::LINE_W'(TOTAL_LINES);

    logic [DOT_W:0]                 dot_sum;
    logic                           line_end;
    logic [DOT_W-1:0]               dot_new;
    logic [lst_pkg::LINE_W-1:0]     line_inc;
    logic [lst_pkg::LINE_W-1:0]     line_new;
    logic                           coinc_new;
    logic [1:0]                     mode;

    // dot_count never reaches a full line, so at most one line ends per tick
    assign dot_sum  = {1'b0, dot_position} + (DOT_W+1)'(dot_count);
    assign line_end = (dot_sum >= DOTS_L);
    assign dot_new  = line_end ? DOT_W'(dot_sum - DOTS_L) : dot_sum[DOT_W-1:0];
    assign line_inc = state.line_count + lst_pkg::LINE_W'(1);

    always_comb
    begin
        line_new  = state.line_count;
        coinc_new = state.coincidence;
        if (line_end)
        begin
            coinc_new = (line_inc == line_compare);
            line_new  = (line_inc != VIS_L && line_inc == TOT_L) ? '0 : line_inc;
        end
    end

    always_comb
    begin
        priority if (line_new >= VIS_L)
            mode = lst_pkg::MODE_VBLANK;
        else if (dot_new < OAM_END)
            mode = lst_pkg::MODE_OAMSCAN;
        else if (dot_new < DRAW_END)
            mode = lst_pkg::MODE_DRAW;
        else
            mode = lst_pkg::MODE_HBLANK;
    end

    always_comb
    begin
        state_next        = state;
        dot_position_next = '0;
        result            = '0;
        if (!display_enable)
        begin
            // hold last mode and coincidence, clear the counters
            state_next.line_count  = '0;
            state_next.status_mode = lst_pkg::MODE_HBLANK;
            result.compare_match   = state.coincidence;
        end
        else
        begin
            dot_position_next      = dot_new;
            state_next.line_count  = line_new;
            state_next.coincidence = coinc_new;
            if (line_end && state.line_count < VIS_L)
            begin
                result.line_done        = 1'b1;
                result.done_line_number = state.line_count;
            end
            if (line_end && line_inc == VIS_L)
                result.vblank_request = 1'b1;
            if (line_end && coinc_new && status_irq_enables[lst_pkg::IRQ_COMPARE_BIT])
                result.status_request = 1'b1;
            if (mode != state.last_mode)
            begin
                state_next.last_mode   = mode;
                state_next.status_mode = mode;
                unique case (mode)
                    lst_pkg::MODE_HBLANK:
                        if (status_irq_enables[lst_pkg::IRQ_HBLANK_BIT])
                            result.status_request = 1'b1;
                    lst_pkg::MODE_VBLANK:
                        if (status_irq_enables[lst_pkg::IRQ_VBLANK_BIT])
                            result.status_request = 1'b1;
                    lst_pkg::MODE_OAMSCAN:
                        if (status_irq_enables[lst_pkg::IRQ_OAMSCAN_BIT])
                            result.status_request = 1'b1;
                    lst_pkg::MODE_DRAW:
                        ;
                endcase
            end
            result.line_number   = line_new;
            result.display_mode  = state_next.status_mode;
            result.compare_match = coinc_new;
        end
    end

endmodule

`default_nettype wire
